[hw/rtl/muv_pkg.sv]
// Shared types and byte class codes for the modified UTF-8 validator.
package muv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic error_so_far;
        logic string_done;
        logic string_valid;
    } out_item_t;

    typedef enum logic [3:0] {
        CLS_ASCII   = 4'd0,
        CLS_ZERO    = 4'd1,
        CLS_C0      = 4'd2,
        CLS_LEAD2   = 4'd3,
        CLS_E0      = 4'd4,
        CLS_ED      = 4'd5,
        CLS_LEAD3   = 4'd6,
        CLS_INVALID = 4'd7,
        CLS_CONT80  = 4'd8,
        CLS_CONT8X  = 4'd9,
        CLS_CONTAX  = 4'd10,
        CLS_CONTBX  = 4'd11
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic        last_byte;
    } cls_item_t;

    localparam int QueueDepth = 2;

    localparam logic [7:0] ByteAsciiLo = 8'h01;
    localparam logic [7:0] ByteAsciiHi = 8'h7F;
    localparam logic [7:0] ByteC0      = 8'hC0;
    localparam logic [7:0] ByteLead2Lo = 8'hC2;
    localparam logic [7:0] ByteLead2Hi = 8'hDF;
    localparam logic [7:0] ByteE0      = 8'hE0;
    localparam logic [7:0] ByteED      = 8'hED;
    localparam logic [7:0] ByteLead3Hi = 8'hEF;
    localparam logic [7:0] Byte80      = 8'h80;
    localparam logic [7:0] Byte9F      = 8'h9F;
    localparam logic [7:0] ByteAF      = 8'hAF;
    localparam logic [7:0] ByteBF      = 8'hBF;

endpackage

[hw/rtl/muv_front.sv]
// Front end: accepts input beats and sorts each byte into a class.
module muv_front (
    input  logic                 push,
    input  muv_pkg::in_item_t    item,
    output logic                 full,
    input  logic                 q_full,
    output logic                 q_push,
    output muv_pkg::cls_item_t   q_wdata
);

    muv_pkg::byte_class_t cls;
    logic [7:0]           b;

    assign b = item.data_byte;

    always_comb
    begin
        if (b == 8'h00)
            cls = muv_pkg::CLS_ZERO;
        else if (b >= muv_pkg::ByteAsciiLo && b <= muv_pkg::ByteAsciiHi)
            cls = muv_pkg::CLS_ASCII;
        else if (b == muv_pkg::Byte80)
            cls = muv_pkg::CLS_CONT80;
        else if (b <= muv_pkg::Byte9F)
            cls = muv_pkg::CLS_CONT8X;
        else if (b <= muv_pkg::ByteAF)
            cls = muv_pkg::CLS_CONTAX;
        else if (b <= muv_pkg::ByteBF)
            cls = muv_pkg::CLS_CONTBX;
        else if (b == muv_pkg::ByteC0)
            cls = muv_pkg::CLS_C0;
        else if (b >= muv_pkg::ByteLead2Lo && b <= muv_pkg::ByteLead2Hi)
            cls = muv_pkg::CLS_LEAD2;
        else if (b == muv_pkg::ByteE0)
            cls = muv_pkg::CLS_E0;
        else if (b == muv_pkg::ByteED)
            cls = muv_pkg::CLS_ED;
        else if (b > muv_pkg::ByteE0 && b <= muv_pkg::ByteLead3Hi)
            cls = muv_pkg::CLS_LEAD3;
        else
            cls = muv_pkg::CLS_INVALID;
    end

    assign full              = q_full;
    assign q_push            = push && !q_full;
    assign q_wdata.cls       = cls;
    assign q_wdata.last_byte = item.last_byte;

endmodule

[hw/rtl/muv_queue.sv]
// Short queue of classified bytes between the front end and the back end.
module muv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  muv_pkg::cls_item_t  wdata,
    output logic                full,
    input  logic                pop,
    output muv_pkg::cls_item_t  rdata,
    output logic                empty
);

    localparam int PtrW = $clog2(muv_pkg::QueueDepth);
    localparam int CntW = $clog2(muv_pkg::QueueDepth + 1);

    muv_pkg::cls_item_t mem_reg [muv_pkg::QueueDepth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = count_reg == CntW'(muv_pkg::QueueDepth);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(muv_pkg::QueueDepth - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(muv_pkg::QueueDepth - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[hw/rtl/muv_back.sv]
// Back end: sequence state machine, sticky error and the result register.
module muv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  muv_pkg::cls_item_t  q_rdata,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output muv_pkg::out_item_t  result
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_NUL2  = 9'b000000010,
        ST_CONT1 = 9'b000000100,
        ST_E0B2  = 9'b000001000,
        ST_CONT2 = 9'b000010000,
        ST_EDB2  = 9'b000100000,
        ST_SUR3  = 9'b001000000,
        ST_SUR4  = 9'b010000000,
        ST_SUR5  = 9'b100000000
    } seq_state_t;

    seq_state_t         state_reg, state_next, parse_next;
    logic               error_reg, error_next;
    logic               out_valid_reg, out_valid_next;
    muv_pkg::out_item_t out_reg;
    muv_pkg::out_item_t res_next;
    logic               take, bad, is_cont, err_now;
    muv_pkg::byte_class_t cls;

    assign cls     = q_rdata.cls;
    assign take    = !q_empty && (!out_valid_reg || pop);
    assign q_pop   = take;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign is_cont = cls == muv_pkg::CLS_CONT80 || cls == muv_pkg::CLS_CONT8X
                  || cls == muv_pkg::CLS_CONTAX || cls == muv_pkg::CLS_CONTBX;

    always_comb
    begin
        parse_next = ST_IDLE;
        bad        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                bad = 1'b0;
                case (cls)
                    muv_pkg::CLS_ASCII: parse_next = ST_IDLE;
                    muv_pkg::CLS_C0:    parse_next = ST_NUL2;
                    muv_pkg::CLS_LEAD2: parse_next = ST_CONT1;
                    muv_pkg::CLS_E0:    parse_next = ST_E0B2;
                    muv_pkg::CLS_ED:    parse_next = ST_EDB2;
                    muv_pkg::CLS_LEAD3: parse_next = ST_CONT2;
                    default:            bad = 1'b1;
                endcase
            end
            ST_NUL2:
            begin
                bad = cls != muv_pkg::CLS_CONT80;
            end
            ST_CONT1:
            begin
                bad = !is_cont;
            end
            ST_E0B2:
            begin
                if (cls == muv_pkg::CLS_CONTAX || cls == muv_pkg::CLS_CONTBX)
                begin
                    parse_next = ST_CONT1;
                    bad        = 1'b0;
                end
            end
            ST_CONT2:
            begin
                if (is_cont)
                begin
                    parse_next = ST_CONT1;
                    bad        = 1'b0;
                end
            end
            ST_EDB2:
            begin
                if (cls == muv_pkg::CLS_CONT80 || cls == muv_pkg::CLS_CONT8X)
                begin
                    parse_next = ST_CONT1;
                    bad        = 1'b0;
                end
                else if (cls == muv_pkg::CLS_CONTAX)
                begin
                    parse_next = ST_SUR3;
                    bad        = 1'b0;
                end
            end
            ST_SUR3:
            begin
                if (is_cont)
                begin
                    parse_next = ST_SUR4;
                    bad        = 1'b0;
                end
            end
            ST_SUR4:
            begin
                if (cls == muv_pkg::CLS_ED)
                begin
                    parse_next = ST_SUR5;
                    bad        = 1'b0;
                end
            end
            ST_SUR5:
            begin
                if (cls == muv_pkg::CLS_CONTBX)
                begin
                    parse_next = ST_CONT1;
                    bad        = 1'b0;
                end
            end
            default:
            begin
                parse_next = ST_IDLE;
                bad        = 1'b1;
            end
        endcase
        if (bad)
            parse_next = ST_IDLE;
    end

    assign err_now = error_reg || bad;

    always_comb
    begin
        res_next.error_so_far = err_now;
        res_next.string_done  = q_rdata.last_byte;
        res_next.string_valid = q_rdata.last_byte && !err_now && (parse_next == ST_IDLE);

        state_next     = state_reg;
        error_next     = error_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (q_rdata.last_byte)
            begin
                state_next = ST_IDLE;
                error_next = 1'b0;
            end
            else
            begin
                state_next = parse_next;
                error_next = err_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_valid_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.string_valid
                           || (out_reg.string_done && !out_reg.error_so_far)))
        else $error("valid result without done or with error");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_rdata.last_byte) |=> (state_reg == ST_IDLE && !error_reg))
        else $error("state not cleared after last byte");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg && !(take && q_rdata.last_byte)) |=> error_reg)
        else $error("error flag dropped inside a string");

    a_bad_reports_error: assert property (@(posedge clk) disable iff (!rst_n)
        (take && bad) |=> out_reg.error_so_far)
        else $error("invalid byte not reported");
`endif

endmodule

[hw/rtl/modified_utf8_validator.sv]
// Top level of the modified UTF-8 validator: front end, byte queue, back end.
//
// Channel   Direction  Handshake             Payload
// item      in         push / full           data_byte, last_byte
// result    out        pop / empty           error_so_far, string_done, string_valid
//
// One beat in and one beat out per cycle when the result side keeps popping.
// A byte reaches the result ports through the classified-byte queue and then the
// result register of the state machine.
// Reset empties the queue and the result register and returns the parser to idle.
// While the result register is held, the queue absorbs two more bytes before full rises.
module modified_utf8_validator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  muv_pkg::in_item_t   item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output muv_pkg::out_item_t  result
);

    logic               q_full, q_push, q_empty, q_pop;
    muv_pkg::cls_item_t q_wdata, q_rdata;

    muv_front u_front (
        .push    (push),
        .item    (item),
        .full    (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    muv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    muv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[tb/utf8_result_check.sv]
// Result checker for the modified UTF-8 validator: predicts each beat and compares it.
module utf8_result_check
    import muv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  item,
    input  logic      pop,
    input  logic      empty,
    input  out_item_t result,
    output int        fail_count,
    output int        pending
);

    localparam logic [7:0] ByteA0 = 8'hA0;
    localparam logic [7:0] ByteB0 = 8'hB0;

    typedef enum logic [3:0] {
        STG_IDLE,
        STG_NUL2,
        STG_CONT1,
        STG_E0B2,
        STG_CONT2,
        STG_EDB2,
        STG_SUR3,
        STG_SUR4,
        STG_SUR5
    } stage_t;

    stage_t    stage;
    stage_t    nxt_stage;
    logic      err_seen;
    logic      bad_byte;
    out_item_t want_res;
    out_item_t pred_res;
    out_item_t pending_res_q[$];

    function automatic logic is_cont(input logic [7:0] b);
        return b >= Byte80 && b <= ByteBF;
    endfunction

    function automatic stage_t next_stage(input stage_t cur, input logic [7:0] b,
                                          output logic bad);
        stage_t nxt;
        nxt = STG_IDLE;
        bad = 1'b0;
        case (cur)
            STG_IDLE:
            begin
                if (b >= ByteAsciiLo && b <= ByteAsciiHi)
                    nxt = STG_IDLE;
                else if (b == ByteC0)
                    nxt = STG_NUL2;
                else if (b >= ByteLead2Lo && b <= ByteLead2Hi)
                    nxt = STG_CONT1;
                else if (b == ByteE0)
                    nxt = STG_E0B2;
                else if (b == ByteED)
                    nxt = STG_EDB2;
                else if (b > ByteE0 && b <= ByteLead3Hi)
                    nxt = STG_CONT2;
                else
                    bad = 1'b1;
            end
            STG_NUL2:
            begin
                if (b != Byte80)
                    bad = 1'b1;
            end
            STG_CONT1:
            begin
                if (!is_cont(b))
                    bad = 1'b1;
            end
            STG_E0B2:
            begin
                if (b >= ByteA0 && b <= ByteBF)
                    nxt = STG_CONT1;
                else
                    bad = 1'b1;
            end
            STG_CONT2:
            begin
                if (is_cont(b))
                    nxt = STG_CONT1;
                else
                    bad = 1'b1;
            end
            STG_EDB2:
            begin
                if (b >= Byte80 && b <= Byte9F)
                    nxt = STG_CONT1;
                else if (b >= ByteA0 && b <= ByteAF)
                    nxt = STG_SUR3;
                else
                    bad = 1'b1;
            end
            STG_SUR3:
            begin
                if (is_cont(b))
                    nxt = STG_SUR4;
                else
                    bad = 1'b1;
            end
            STG_SUR4:
            begin
                if (b == ByteED)
                    nxt = STG_SUR5;
                else
                    bad = 1'b1;
            end
            STG_SUR5:
            begin
                if (b >= ByteB0 && b <= ByteBF)
                    nxt = STG_CONT1;
                else
                    bad = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        return nxt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage = STG_IDLE;
            err_seen = 1'b0;
            pending_res_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_res_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, got err=%b done=%b valid=%b",
                             $time, result.error_so_far, result.string_done,
                             result.string_valid);
                    fail_count++;
                end
                else
                begin
                    want_res = pending_res_q.pop_front();
                    if (result.error_so_far !== want_res.error_so_far ||
                        result.string_done !== want_res.string_done ||
                        result.string_valid !== want_res.string_valid)
                    begin
                        $display(
                            "%0t: exp err=%b done=%b valid=%b, got err=%b done=%b valid=%b",
                            $time, want_res.error_so_far, want_res.string_done,
                            want_res.string_valid, result.error_so_far,
                            result.string_done, result.string_valid);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                nxt_stage = next_stage(stage, item.data_byte, bad_byte);
                err_seen = err_seen | bad_byte;
                pred_res.error_so_far = err_seen;
                pred_res.string_done = item.last_byte;
                pred_res.string_valid = item.last_byte && !err_seen && nxt_stage == STG_IDLE;
                pending_res_q.push_back(pred_res);
                if (item.last_byte)
                begin
                    stage = STG_IDLE;
                    err_seen = 1'b0;
                end
                else
                begin
                    stage = nxt_stage;
                end
            end
            pending = pending_res_q.size();
        end
    end

endmodule

[tb/tb.sv]
// Testbench top for the modified UTF-8 validator: clock, reset, byte stimulus and verdict.
module tb;
    import muv_pkg::*;

    localparam int ItemTarget = 1850;
    localparam int CycleLimit = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    in_item_t  item = '0;
    logic      full;
    logic      empty;
    out_item_t result;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        bytes_sent = 0;
    logic      steady = 1'b0;
    logic      paused_once = 1'b0;
    logic [7:0] str_bytes[$];

    always #10 clk = ~clk;

    modified_utf8_validator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    utf8_result_check result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .pop        (pop),
        .empty      (empty),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("modified_utf8_validator verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            pop <= steady || ($urandom_range(99) >= 6);
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        if (!steady)
        begin
            while ($urandom_range(99) < 6)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push <= 1'b1;
        item <= '{data_byte: b, last_byte: l};
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_beat(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic append_sequence();
        logic [7:0] lead;
        case ($urandom_range(0, 7))
            0, 1:
                str_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
            2:
            begin
                str_bytes.push_back(ByteC0);
                str_bytes.push_back(Byte80);
            end
            3:
            begin
                str_bytes.push_back(8'($urandom_range(ByteLead2Lo, ByteLead2Hi)));
                str_bytes.push_back(cont_byte());
            end
            4:
            begin
                str_bytes.push_back(ByteE0);
                str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                str_bytes.push_back(cont_byte());
            end
            5:
            begin
                lead = 8'($urandom_range(8'hE1, ByteLead3Hi));
                if (lead == ByteED)
                    lead = 8'hEE;
                str_bytes.push_back(lead);
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            6:
            begin
                str_bytes.push_back(ByteED);
                str_bytes.push_back(8'($urandom_range(Byte80, Byte9F)));
                str_bytes.push_back(cont_byte());
            end
            default:
            begin
                str_bytes.push_back(ByteED);
                str_bytes.push_back(8'($urandom_range(8'hA0, ByteAF)));
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(ByteED);
                str_bytes.push_back(8'($urandom_range(8'hB0, ByteBF)));
                str_bytes.push_back(cont_byte());
            end
        endcase
    endtask

    task automatic build_random_string();
        int n;
        int mode;
        n = ($urandom_range(99) < 5) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            for (int i = 0; i < n; i++)
                str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = 0; i < n; i++)
                append_sequence();
            if (mode < 20)
                str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            else if (mode < 27 && str_bytes.size() > 1)
                void'(str_bytes.pop_back());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        str_bytes = '{8'h00};
        send_string();
        str_bytes = '{ByteC0, Byte80};
        send_string();
        str_bytes = '{ByteLead2Hi, ByteBF};
        send_string();
        str_bytes = '{ByteE0, 8'hA0, Byte80};
        send_string();
        str_bytes = '{ByteED, 8'hA0, ByteBF, ByteED, ByteBF, Byte80};
        send_string();
        str_bytes = '{ByteED, Byte9F, Byte80};
        send_string();
        str_bytes = '{8'hC1, ByteAsciiLo};
        send_string();
        str_bytes = '{8'hFF};
        send_string();
        str_bytes = '{8'hE1};
        send_string();
        str_bytes = '{ByteED, 8'hA0, Byte80, ByteAsciiHi};
        send_string();
        str_bytes = '{Byte80, 8'hF0, ByteAsciiLo};
        send_string();

        while (bytes_sent < ItemTarget)
        begin
            steady <= (bytes_sent >= 700 && bytes_sent < 1000);
            if (!paused_once && bytes_sent >= 1200)
            begin
                push <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                @(posedge clk);
                paused_once = 1'b1;
            end
            build_random_string();
            send_string();
        end
        push <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("modified_utf8_validator verification clean");
        else
            $display("modified_utf8_validator verification failed");
        $finish;
    end

endmodule

[modified_utf8_validator.f]
hw/rtl/muv_pkg.sv
hw/rtl/muv_front.sv
hw/rtl/muv_queue.sv
hw/rtl/muv_back.sv
hw/rtl/modified_utf8_validator.sv
tb/utf8_result_check.sv
tb/tb.sv
